### design/dual_bitset_engine_core_macros.svh
// ----------------------------------------------------------------------------
// dual_bitset_engine_core_macros.svh
// Assertion shorthands used by the bitset engine checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_BITSET_ENGINE_CORE_MACROS_SVH
`define DUAL_BITSET_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dbe_pkg.sv
// ----------------------------------------------------------------------------
// dbe_pkg
// Shared types and constants of the dual bitset engine.
// ----------------------------------------------------------------------------
package dbe_pkg;

  // field widths
  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // range register reset values
  localparam logic signed [CFG_W-1:0] RANGE_LOW_RESET  = 16'sd0;
  localparam logic signed [CFG_W-1:0] RANGE_HIGH_RESET = 16'sd255;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_SET        = 4'd0,
    ACT_CLEAR      = 4'd1,
    ACT_TOGGLE     = 4'd2,
    ACT_GET        = 4'd3,
    ACT_SET_ALL    = 4'd4,
    ACT_CLEAR_ALL  = 4'd5,
    ACT_TOGGLE_ALL = 4'd6,
    ACT_AND        = 4'd7,
    ACT_OR         = 4'd8,
    ACT_XOR        = 4'd9,
    ACT_SUBTRACT   = 4'd10,
    ACT_ANY        = 4'd11,
    ACT_ALL        = 4'd12
  } action_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } cfg_reg_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture accepted beat, range check, size
    logic cnt_rst;    // word counter back to zero
    logic cnt_inc;    // next word
    logic clr_wr;     // clearing pass write at counter address
    logic rd;         // read target and operand words
    logic wr;         // write back updated target word
    logic load_out;   // load result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic skip_in;    // incoming beat needs no word walk
    logic clr_last;   // counter at last memory entry
    logic word_last;  // counter at last word of a bank
    logic bit_done;   // per-bit action found its word
  } status_t;

endpackage

### design/dbe_in_if.sv
// ----------------------------------------------------------------------------
// dbe_in_if
// Command channel of the bitset engine: action, bank and bit index.
// ----------------------------------------------------------------------------
interface dbe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [dbe_pkg::ACTION_W-1:0]  action;
  logic                                 bank;
  logic signed [dbe_pkg::INDEX_W-1:0]   bit_index;

  modport source (output valid, action, bank, bit_index, input ready);
  modport sink   (input valid, action, bank, bit_index, output ready);
endinterface

### design/dbe_out_if.sv
// ----------------------------------------------------------------------------
// dbe_out_if
// Result channel of the bitset engine: answer bit and range error flag.
// ----------------------------------------------------------------------------
interface dbe_out_if;
  logic valid;
  logic ready;
  logic answer;
  logic range_error;

  modport source (output valid, answer, range_error, input ready);
  modport sink   (input valid, answer, range_error, output ready);
endinterface

### design/dbe_datapath.sv
// ----------------------------------------------------------------------------
// dbe_datapath
// Range registers, index check, bank memory and the per-word update logic.
// ----------------------------------------------------------------------------
module dbe_datapath #(
  parameter int unsigned SET_BITS  = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [dbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [dbe_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic        [dbe_pkg::ACTION_W-1:0]   in_action_i,
  input  logic                                  in_bank_i,
  input  logic signed [dbe_pkg::INDEX_W-1:0]    in_index_i,
  input  dbe_pkg::cmd_t                         cmd_i,
  output dbe_pkg::status_t                      status_o,
  output logic                                  answer_o,
  output logic                                  range_error_o
);

  localparam int unsigned BANK_WORDS = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned MEM_WORDS  = 2 * BANK_WORDS;
  localparam int unsigned AW         = $clog2(MEM_WORDS);
  localparam int unsigned KW         = $clog2(SET_BITS);
  localparam int unsigned NW         = $clog2(SET_BITS + 1);
  localparam int unsigned BASE_W     = $clog2(BANK_WORDS * WORD_BITS + 1);
  localparam int unsigned JW         = $clog2(WORD_BITS);

  // range registers
  logic signed [dbe_pkg::CFG_W-1:0] lo_q, hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= dbe_pkg::RANGE_LOW_RESET;
      hi_q <= dbe_pkg::RANGE_HIGH_RESET;
    end else if (cfg_we_i) begin
      unique case (dbe_pkg::cfg_reg_e'(cfg_idx_i))
        dbe_pkg::REG_RANGE_LOW:  lo_q <= $signed(cfg_data_i);
        dbe_pkg::REG_RANGE_HIGH: hi_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // index check of the incoming beat
  logic signed [dbe_pkg::INDEX_W:0]   off_s;
  logic signed [dbe_pkg::INDEX_W+1:0] size_s;
  logic                               per_bit_in, unused_in, bad_in;
  logic [NW-1:0]                      n_in;

  assign off_s = $signed({in_index_i[dbe_pkg::INDEX_W-1], in_index_i})
               - $signed({lo_q[dbe_pkg::CFG_W-1], lo_q});
  assign per_bit_in = (in_action_i <= dbe_pkg::ACT_GET);
  assign unused_in  = (in_action_i > dbe_pkg::ACT_ALL);
  assign bad_in     = per_bit_in && ((in_index_i < lo_q) || (in_index_i > hi_q) ||
                      (off_s >= $signed((dbe_pkg::INDEX_W+1)'(SET_BITS))));

  // effective range size, clipped to 0..SET_BITS
  assign size_s = $signed({{2{hi_q[dbe_pkg::CFG_W-1]}}, hi_q})
                - $signed({{2{lo_q[dbe_pkg::CFG_W-1]}}, lo_q})
                + $signed((dbe_pkg::INDEX_W+2)'(1));

  always_comb begin
    if (size_s <= $signed((dbe_pkg::INDEX_W+2)'(0))) begin
      n_in = '0;
    end else if (size_s > $signed((dbe_pkg::INDEX_W+2)'(SET_BITS))) begin
      n_in = NW'(SET_BITS);
    end else begin
      n_in = size_s[NW-1:0];
    end
  end

  // item registers
  dbe_pkg::action_e act_q;
  logic             bank_q, err_q, acc_q;
  logic [KW-1:0]    k_q;
  logic [NW-1:0]    n_q;

  // word counter and bit offset of the current word
  logic [AW-1:0]     cnt_q;
  logic [BASE_W-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.cnt_rst) begin
      cnt_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q  <= cnt_q + AW'(1);
      base_q <= base_q + BASE_W'(WORD_BITS);
    end
  end

  // bank memory: bank A words, then bank B words
  logic [WORD_BITS-1:0] mem_q [MEM_WORDS];
  logic [WORD_BITS-1:0] tw_q, ow_q, new_word;
  logic [AW-1:0]        addr_t, addr_o;

  assign addr_t = bank_q ? (AW'(BANK_WORDS) + cnt_q) : cnt_q;
  assign addr_o = bank_q ? cnt_q : (AW'(BANK_WORDS) + cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[cnt_q] <= '0;
    end else if (cmd_i.wr) begin
      mem_q[addr_t] <= new_word;
    end
    if (cmd_i.rd) begin
      tw_q <= mem_q[addr_t];
      ow_q <= mem_q[addr_o];
    end
  end

  // bit position within the current word
  logic [BASE_W-1:0]    k_ext;
  logic                 hit;
  logic [JW-1:0]        jpos;
  logic [WORD_BITS-1:0] bit_sel, lane_mask;

  assign k_ext   = BASE_W'(k_q);
  assign hit     = (k_ext >= base_q) && (k_ext < (base_q + BASE_W'(WORD_BITS)));
  assign jpos    = JW'(k_ext - base_q);
  assign bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << jpos;

  // lanes of this word that lie inside the range size
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lane_mask[j] = (({1'b0, base_q} + (BASE_W+1)'(j)) < (BASE_W+1)'(n_q));
    end
  end

  // updated target word
  always_comb begin
    case (act_q)
      dbe_pkg::ACT_SET:        new_word = hit ? (tw_q | bit_sel)  : tw_q;
      dbe_pkg::ACT_CLEAR:      new_word = hit ? (tw_q & ~bit_sel) : tw_q;
      dbe_pkg::ACT_TOGGLE:     new_word = hit ? (tw_q ^ bit_sel)  : tw_q;
      dbe_pkg::ACT_SET_ALL:    new_word = '1;
      dbe_pkg::ACT_CLEAR_ALL:  new_word = '0;
      dbe_pkg::ACT_TOGGLE_ALL: new_word = ~tw_q;
      dbe_pkg::ACT_AND:        new_word = tw_q & ow_q;
      dbe_pkg::ACT_OR:         new_word = tw_q | ow_q;
      dbe_pkg::ACT_XOR:        new_word = tw_q ^ ow_q;
      dbe_pkg::ACT_SUBTRACT:   new_word = tw_q & ~ow_q;
      default:                 new_word = tw_q;
    endcase
  end

  // item capture and answer accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q  <= dbe_pkg::action_e'(in_action_i);
      bank_q <= in_bank_i;
      k_q    <= off_s[KW-1:0];
      err_q  <= bad_in;
      n_q    <= n_in;
      acc_q  <= (in_action_i == dbe_pkg::ACT_ALL);
    end else if (cmd_i.wr) begin
      case (act_q)
        dbe_pkg::ACT_GET: if (hit) acc_q <= |(tw_q & bit_sel);
        dbe_pkg::ACT_ANY: acc_q <= acc_q | (|(tw_q & lane_mask));
        dbe_pkg::ACT_ALL: acc_q <= acc_q & (&(tw_q | ~lane_mask));
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      answer_o      <= acc_q && !err_q;
      range_error_o <= err_q;
    end
  end

  // status to the controller
  assign status_o.skip_in   = bad_in || unused_in;
  assign status_o.clr_last  = (cnt_q == AW'(MEM_WORDS - 1));
  assign status_o.word_last = (cnt_q == AW'(BANK_WORDS - 1));
  assign status_o.bit_done  = (act_q <= dbe_pkg::ACT_GET) && hit;

endmodule

### design/dbe_ctrl.sv
// ----------------------------------------------------------------------------
// dbe_ctrl
// Sequencer of the bitset engine: clearing pass, word walk, result handoff.
// ----------------------------------------------------------------------------
module dbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dbe_pkg::status_t  status_i,
  output dbe_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic          out_valid_q, out_valid_d;
  dbe_pkg::cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          cmd.cnt_rst = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          cmd.cnt_rst   = 1'b1;
          state_d       = status_i.skip_in ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd  = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (status_i.bit_done || status_i.word_last) begin
          state_d = ST_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_DONE: begin
        // hand off once the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

### design/dual_bitset_engine_core.sv
// ----------------------------------------------------------------------------
// dual_bitset_engine_core
// Two bit sets over one shared index range with per-bit and set algebra.
// ----------------------------------------------------------------------------
// Each command beat gives exactly one result beat. Both banks live in one
// memory of 2*ceil(SET_BITS/WORD_BITS) words, read at two addresses per
// cycle, and the controller walks it one word at a time, a read state then
// a write state per word. After reset a clearing pass zeroes the memory; no
// command is taken meanwhile, range writes are. A bad index or an unused
// action skips the word walk and goes straight to the result handoff; a
// per-bit action walks the words up to the one that holds its bit; a
// whole-set action, any or all walks every word of the bank. The result
// register lets a new command in while the previous result still waits to
// be taken.
// ----------------------------------------------------------------------------
module dual_bitset_engine_core #(
  parameter int unsigned SET_BITS  = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dbe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dbe_pkg::CFG_W-1:0]         cfg_data_i,
  dbe_in_if.sink                            in_i,
  dbe_out_if.source                         out_o
);

  dbe_pkg::cmd_t    cmd;
  dbe_pkg::status_t status;

  // sequencer
  dbe_ctrl u_dbe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // storage and update logic
  dbe_datapath #(
    .SET_BITS  (SET_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dbe_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_action_i   (in_i.action),
    .in_bank_i     (in_i.bank),
    .in_index_i    (in_i.bit_index),
    .cmd_i         (cmd),
    .status_o      (status),
    .answer_o      (out_o.answer),
    .range_error_o (out_o.range_error)
  );

endmodule

### design/dbe_checker.sv
// ----------------------------------------------------------------------------
// dbe_checker
// Port-level checks of the bitset engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_bitset_engine_core_macros.svh"

module dbe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_answer_i,
  input logic out_range_error_i
);

  // a stalled result beat holds
  `DBE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_answer_i) && $stable(out_range_error_i), "result beat changed while stalled")

  // one command at a time: ready drops after an accept
  `DBE_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "command accepted while busy")

  // a range error never carries an answer
  `DBE_ASSERT_IMP(a_err_no_answer, clk_i, rst_ni, out_valid_i && out_range_error_i, !out_answer_i, "answer set on range error")

  // a new result only comes out of a busy cycle
  `DBE_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i), "result appeared while idle")

endmodule

bind dual_bitset_engine_core dbe_checker u_dbe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_answer_i      (out_o.answer),
  .out_range_error_i (out_o.range_error)
);
